// ===== design/dispense_job_sequencer_top_assert.svh =====
// assertion macros for the dispense job sequencer
`ifndef DISPENSE_JOB_SEQUENCER_TOP_ASSERT_SVH
`define DISPENSE_JOB_SEQUENCER_TOP_ASSERT_SVH

`ifndef SYNTH
`define DJS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("dispense job sequencer check failed");
`define DJS_ASSERT_NEXT(label, cond, nxt) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error("dispense job sequencer sequence check failed");
`else
`define DJS_ASSERT(label, prop)
`define DJS_ASSERT_NEXT(label, cond, nxt)
`endif

`endif

// ===== design/djs_pkg.sv =====
package djs_pkg;

    localparam int KIND_W = 3;
    localparam int SLOT_W = 3;
    localparam int MOD_W  = 4;
    localparam int CNT_W  = 8;
    localparam int MASK_W = 7;
    localparam int EV_W   = 3;
    localparam int HOLD_W = 12;
    localparam int PH_W   = 3;

    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SLOT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOTE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SERVO  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd4;

    localparam logic [EV_W-1:0] EV_ACCEPT    = 3'd0;
    localparam logic [EV_W-1:0] EV_REJECT    = 3'd1;
    localparam logic [EV_W-1:0] EV_START     = 3'd2;
    localparam logic [EV_W-1:0] EV_DISPENSED = 3'd3;
    localparam logic [EV_W-1:0] EV_JAMMED    = 3'd4;
    localparam logic [EV_W-1:0] EV_FINISHED  = 3'd5;
    localparam logic [EV_W-1:0] EV_HOME      = 3'd6;

    localparam logic [PH_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PH_W-1:0] PH_START      = 3'd1;
    localparam logic [PH_W-1:0] PH_WAIT_SERVO = 3'd2;
    localparam logic [PH_W-1:0] PH_SHOW       = 3'd3;
    localparam logic [PH_W-1:0] PH_HOLD       = 3'd4;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 12'd3000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot_index;
        logic [MOD_W-1:0]  module_index;
        logic              servo_ok;
        logic [CNT_W-1:0]  load_count;
        logic [MASK_W-1:0] load_slot_mask;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [MOD_W-1:0]  module_number;
        logic [CNT_W-1:0]  count_left;
        logic              from_remote;
        logic [SLOT_W-1:0] job_slot;
    } result_t;

    typedef struct packed {
        logic              en;
        logic              mask_en;
        logic [MOD_W-1:0]  addr;
        logic [CNT_W-1:0]  count;
        logic [MASK_W-1:0] mask;
    } store_wr_t;

    typedef struct packed {
        logic            busy;
        logic [PH_W-1:0] phase;
    } seq_stat_t;

endpackage

// ===== design/djs_store.sv =====
module djs_store
    import djs_pkg::*;
#(
    parameter int MODULES = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [MOD_W-1:0]  rd_addr,
    output logic [CNT_W-1:0]  rd_count,
    output logic [MASK_W-1:0] rd_mask,
    input  store_wr_t         wr
);

    localparam int MIDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam logic [MOD_W-1:0] MOD_LIMIT = MOD_W'(MODULES);

    logic [CNT_W-1:0]  counts_reg [MODULES];
    logic [MASK_W-1:0] masks_reg  [MODULES];

    // single read port, out-of-range modules read as empty
    always_comb begin
        if (rd_addr < MOD_LIMIT) begin
            rd_count = counts_reg[rd_addr[MIDX_W-1:0]];
            rd_mask  = masks_reg[rd_addr[MIDX_W-1:0]];
        end else begin
            rd_count = '0;
            rd_mask  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MODULES; i++) begin
                counts_reg[i] <= '0;
                masks_reg[i]  <= '0;
            end
        end else if (wr.en && wr.addr < MOD_LIMIT) begin
            counts_reg[wr.addr[MIDX_W-1:0]] <= wr.count;
            if (wr.mask_en) begin
                masks_reg[wr.addr[MIDX_W-1:0]] <= wr.mask;
            end
        end
    end

endmodule

// ===== design/djs_seq.sv =====
module djs_seq
    import djs_pkg::*;
#(
    parameter int MODULES = 6,
    parameter int SLOTS   = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  item_t             item,
    output logic              in_ready,
    input  logic [HOLD_W-1:0] hold_ticks,
    output logic [MOD_W-1:0]  rd_addr,
    input  logic [CNT_W-1:0]  rd_count,
    input  logic [MASK_W-1:0] rd_mask,
    output store_wr_t         wr,
    output logic              res_valid,
    output result_t           res,
    input  logic              out_free,
    output seq_stat_t         stat
);

    localparam logic [MOD_W-1:0]  MOD_LIMIT  = MOD_W'(MODULES);
    localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(SLOTS);
    localparam logic [MASK_W-1:0] SLOT_MASK  = MASK_W'((1 << SLOTS) - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]        st_reg,     st_next;
    item_t             item_reg,   item_next;
    logic [PH_W-1:0]   phase_reg,  phase_next;
    logic              remote_reg, remote_next;
    logic [SLOT_W-1:0] slot_reg,   slot_next;
    logic [MOD_W-1:0]  cur_reg,    cur_next;
    logic [HOLD_W-1:0] hold_reg,   hold_next;
    result_t           res_reg,    res_next;

    logic [CNT_W-1:0]  left;
    logic              scan_hit;
    logic [HOLD_W:0]   hold_inc;

    assign in_ready   = (st_reg == ST_IDLE);
    assign res_valid  = (st_reg == ST_OUT);
    assign res        = res_reg;
    assign stat.busy  = (st_reg != ST_IDLE);
    assign stat.phase = phase_reg;

    // remote requests check the requested module, everything else the current one
    assign rd_addr = (st_reg == ST_EXEC && item_reg.kind == KIND_REMOTE) ?
                     item_reg.module_index : cur_reg;

    assign left     = (rd_count == '0) ? '0 : rd_count - CNT_W'(1);
    assign scan_hit = remote_reg || (rd_mask[slot_reg] && rd_count != '0);
    assign hold_inc = {1'b0, hold_reg} + (HOLD_W+1)'(1);

    always_comb begin
        st_next     = st_reg;
        item_next   = item_reg;
        phase_next  = phase_reg;
        remote_next = remote_reg;
        slot_next   = slot_reg;
        cur_next    = cur_reg;
        hold_next   = hold_reg;
        res_next    = res_reg;
        wr          = '0;

        unique case (st_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    item_next = item;
                    st_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                st_next = ST_IDLE;
                case (item_reg.kind)
                    KIND_TICK: begin
                        case (phase_reg)
                            PH_START: st_next = ST_SCAN;
                            PH_SHOW: begin
                                hold_next  = '0;
                                phase_next = PH_HOLD;
                                res_next   = '{EV_FINISHED, '0, '0, remote_reg, slot_reg};
                                st_next    = ST_OUT;
                            end
                            PH_HOLD: begin
                                if (hold_inc >= {1'b0, hold_ticks}) begin
                                    phase_next = PH_IDLE;
                                    hold_next  = '0;
                                    res_next   = '{EV_HOME, '0, '0, remote_reg, slot_reg};
                                    st_next    = ST_OUT;
                                end else begin
                                    hold_next = hold_inc[HOLD_W-1:0];
                                end
                            end
                            default: ;
                        endcase
                    end
                    KIND_SLOT: begin
                        if (phase_reg != PH_IDLE || item_reg.slot_index >= SLOT_LIMIT) begin
                            res_next = '{EV_REJECT, '0, '0, 1'b0, item_reg.slot_index};
                        end else begin
                            phase_next  = PH_START;
                            remote_next = 1'b0;
                            slot_next   = item_reg.slot_index;
                            cur_next    = '0;
                            res_next    = '{EV_ACCEPT, '0, '0, 1'b0, item_reg.slot_index};
                        end
                        st_next = ST_OUT;
                    end
                    KIND_REMOTE: begin
                        if (phase_reg != PH_IDLE || item_reg.module_index >= MOD_LIMIT ||
                            rd_count == '0) begin
                            res_next = '{EV_REJECT, item_reg.module_index, '0, 1'b1, '0};
                        end else begin
                            phase_next  = PH_START;
                            remote_next = 1'b1;
                            slot_next   = '0;
                            cur_next    = item_reg.module_index;
                            res_next    = '{EV_ACCEPT, item_reg.module_index, '0, 1'b1, '0};
                        end
                        st_next = ST_OUT;
                    end
                    KIND_SERVO: begin
                        if (phase_reg == PH_WAIT_SERVO && cur_reg < MOD_LIMIT) begin
                            if (item_reg.servo_ok) begin
                                wr.en    = 1'b1;
                                wr.addr  = cur_reg;
                                wr.count = left;
                                res_next = '{EV_DISPENSED, cur_reg, left, remote_reg, slot_reg};
                            end else begin
                                res_next = '{EV_JAMMED, cur_reg, '0, remote_reg, slot_reg};
                            end
                            if (remote_reg) begin
                                cur_next   = MOD_LIMIT;
                                phase_next = PH_SHOW;
                            end else begin
                                cur_next   = cur_reg + MOD_W'(1);
                                phase_next = PH_START;
                            end
                            st_next = ST_OUT;
                        end
                    end
                    KIND_LOAD: begin
                        wr.en      = 1'b1;
                        wr.mask_en = 1'b1;
                        wr.addr    = item_reg.module_index;
                        wr.count   = item_reg.load_count;
                        wr.mask    = item_reg.load_slot_mask & SLOT_MASK;
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                // one module per cycle through the shared read port
                if (cur_reg >= MOD_LIMIT) begin
                    phase_next = PH_SHOW;
                    st_next    = ST_IDLE;
                end else if (scan_hit) begin
                    phase_next = PH_WAIT_SERVO;
                    res_next   = '{EV_START, cur_reg, '0, remote_reg, slot_reg};
                    st_next    = ST_OUT;
                end else begin
                    cur_next = cur_reg + MOD_W'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            phase_reg  <= PH_IDLE;
            remote_reg <= 1'b0;
            slot_reg   <= '0;
            cur_reg    <= '0;
            hold_reg   <= '0;
        end else begin
            st_reg     <= st_next;
            phase_reg  <= phase_next;
            remote_reg <= remote_next;
            slot_reg   <= slot_next;
            cur_reg    <= cur_next;
            hold_reg   <= hold_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

endmodule

// ===== design/dispense_job_sequencer_top.sv =====
// an accepted item is registered, executed in the EXEC state, and any result is
// registered and then handed to the output register; a tick that starts a module
// scan first steps through the modules in the SCAN state, one module per cycle;
// one item at a time, and a result waits for room in the output register (m_tready)
// reset: aresetn synchronous active low, clears counts, masks, job state, hold time 3000
module dispense_job_sequencer_top
    import djs_pkg::*;
#(
    parameter int MODULES = 6,
    parameter int SLOTS   = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [11:0] cfg_wdata,   // result_hold_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // slot_index, module_index, servo_ok, load_count,
                                     // load_slot_mask, one unused bit
    input  logic [2:0]  s_tuser,     // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // module_number, count_left, from_remote, job_slot
    output logic [2:0]  m_tuser      // event_res
);

    `include "dispense_job_sequencer_top_assert.svh"

    logic [HOLD_W-1:0] hold_ticks_reg;
    logic              m_valid_reg;
    result_t           m_data_reg;

    item_t             item;
    logic [MOD_W-1:0]  rd_addr;
    logic [CNT_W-1:0]  rd_count;
    logic [MASK_W-1:0] rd_mask;
    store_wr_t         wr;
    logic              res_valid;
    result_t           res;
    logic              out_free;
    seq_stat_t         stat;

    assign item.kind           = s_tuser;
    assign item.slot_index     = s_tdata[2:0];
    assign item.module_index   = s_tdata[6:3];
    assign item.servo_ok       = s_tdata[7];
    assign item.load_count     = s_tdata[15:8];
    assign item.load_slot_mask = s_tdata[22:16];

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg <= HOLD_RESET;
        end else if (cfg_we) begin
            hold_ticks_reg <= cfg_wdata;
        end
    end

    djs_store #(
        .MODULES (MODULES)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_count (rd_count),
        .rd_mask  (rd_mask),
        .wr       (wr)
    );

    djs_seq #(
        .MODULES (MODULES),
        .SLOTS   (SLOTS)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .item       (item),
        .in_ready   (s_tready),
        .hold_ticks (hold_ticks_reg),
        .rd_addr    (rd_addr),
        .rd_count   (rd_count),
        .rd_mask    (rd_mask),
        .wr         (wr),
        .res_valid  (res_valid),
        .res        (res),
        .out_free   (out_free),
        .stat       (stat)
    );

    // output register decouples the sequencer from the downstream stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_free) begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.event_res;
    assign m_tdata  = {m_data_reg.job_slot, m_data_reg.from_remote,
                       m_data_reg.count_left, m_data_reg.module_number};

    `DJS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready && stat.busy)
    `DJS_ASSERT(a_home_idle, (res_valid && res.event_res == EV_HOME) |-> stat.phase == PH_IDLE)
    `DJS_ASSERT(a_count_zero, (m_tvalid && m_tuser != EV_DISPENSED) |-> m_tdata[11:4] == '0)

endmodule

// ===== dv/dispense_job_sequencer_top_tb.sv =====
`timescale 1ns / 100ps

module dispense_job_sequencer_top_tb
    import djs_pkg::*;
();

    localparam int NMOD = 6;
    localparam int NSLOT = 7;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 30;
    localparam logic [KIND_W-1:0] KIND_TOP = 3'd7;  // highest undefined kind, ignored
    localparam logic [MASK_W-1:0] SLOT_BITS = 7'((1 << NSLOT) - 1);

    typedef struct packed {
        logic [HOLD_W-1:0]             hold_cfg;
        logic [PH_W-1:0]               phase;
        logic                          running;
        logic                          remote;
        logic [SLOT_W-1:0]             slot;
        logic [MOD_W-1:0]              mod_ptr;
        logic [HOLD_W-1:0]             timer;
        logic [NMOD-1:0][CNT_W-1:0]    counts;
        logic [NMOD-1:0][MASK_W-1:0]   masks;
    } seq_state_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    item_t      cmd_q[$];
    result_t    due_events[$];
    item_t      cur_cmd;
    seq_state_t gen_seq;
    seq_state_t chk_seq;
    seq_state_t chk_next;
    result_t    chk_ev;
    int         cycle_cnt = 0;
    int         err_cnt = 0;
    int         phase_items;
    logic       calm;

    // a recurring quiet window where neither side idles
    assign calm = (cycle_cnt % 6000) >= 4500;

    dispense_job_sequencer_top #(
        .MODULES(NMOD),
        .SLOTS  (NSLOT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic result_t make_event(input logic [EV_W-1:0] ev, input logic [MOD_W-1:0] mod,
                                           input logic [CNT_W-1:0] cnt, input logic rem,
                                           input logic [SLOT_W-1:0] slot);
        result_t r;
        r.event_res = ev;
        r.module_number = mod;
        r.count_left = cnt;
        r.from_remote = rem;
        r.job_slot = slot;
        return r;
    endfunction

    // sequencer behavior for one item; returns 1 when the item yields an event
    function automatic bit next_event(input seq_state_t cur, input item_t it,
                                      output seq_state_t nxt, output result_t ev);
        int m;
        int t;
        bit hit;
        bit found;
        logic [SLOT_W-1:0] jslot;
        nxt = cur;
        ev = '0;
        hit = 1'b0;
        found = 1'b0;
        jslot = cur.remote ? '0 : cur.slot;
        case (it.kind)
            KIND_TICK: begin
                if (cur.running && cur.phase == PH_START) begin
                    m = cur.mod_ptr;
                    if (!cur.remote) begin
                        // scheduled job: skip modules without the slot bit or without pills
                        while (m < NMOD && !found) begin
                            if (cur.masks[m][cur.slot] && cur.counts[m] != '0) begin
                                found = 1'b1;
                            end else begin
                                m++;
                            end
                        end
                    end
                    nxt.mod_ptr = 4'(m);
                    if (m >= NMOD) begin
                        nxt.phase = PH_SHOW;
                    end else begin
                        nxt.phase = PH_WAIT_SERVO;
                        ev = make_event(EV_START, 4'(m), '0, cur.remote, jslot);
                        hit = 1'b1;
                    end
                end else if (cur.running && cur.phase == PH_SHOW) begin
                    nxt.timer = '0;
                    nxt.phase = PH_HOLD;
                    ev = make_event(EV_FINISHED, '0, '0, cur.remote, jslot);
                    hit = 1'b1;
                end else if (cur.running && cur.phase == PH_HOLD) begin
                    t = cur.timer;
                    if (t + 1 >= int'(cur.hold_cfg)) begin
                        nxt.phase = PH_IDLE;
                        nxt.running = 1'b0;
                        nxt.timer = '0;
                        ev = make_event(EV_HOME, '0, '0, cur.remote, jslot);
                        hit = 1'b1;
                    end else begin
                        nxt.timer = cur.timer + 1'b1;
                    end
                end
            end
            KIND_SLOT: begin
                hit = 1'b1;
                if (cur.running || it.slot_index >= NSLOT) begin
                    ev = make_event(EV_REJECT, '0, '0, 1'b0, it.slot_index);
                end else begin
                    nxt.running = 1'b1;
                    nxt.remote = 1'b0;
                    nxt.slot = it.slot_index;
                    nxt.mod_ptr = '0;
                    nxt.phase = PH_START;
                    ev = make_event(EV_ACCEPT, '0, '0, 1'b0, it.slot_index);
                end
            end
            KIND_REMOTE: begin
                hit = 1'b1;
                ev = make_event(EV_REJECT, it.module_index, '0, 1'b1, '0);
                if (!cur.running && it.module_index < NMOD) begin
                    if (cur.counts[it.module_index] != '0) begin
                        nxt.running = 1'b1;
                        nxt.remote = 1'b1;
                        nxt.slot = '0;
                        nxt.mod_ptr = it.module_index;
                        nxt.phase = PH_START;
                        ev.event_res = EV_ACCEPT;
                    end
                end
            end
            KIND_SERVO: begin
                if (cur.running && cur.phase == PH_WAIT_SERVO && cur.mod_ptr < NMOD) begin
                    m = cur.mod_ptr;
                    hit = 1'b1;
                    if (it.servo_ok) begin
                        // a success on an empty module keeps the count at zero
                        if (cur.counts[m] != '0) nxt.counts[m] = cur.counts[m] - 1'b1;
                        ev = make_event(EV_DISPENSED, cur.mod_ptr, nxt.counts[m], cur.remote, jslot);
                    end else begin
                        ev = make_event(EV_JAMMED, cur.mod_ptr, '0, cur.remote, jslot);
                    end
                    if (cur.remote) begin
                        nxt.mod_ptr = 4'(NMOD);
                        nxt.phase = PH_SHOW;
                    end else begin
                        nxt.mod_ptr = cur.mod_ptr + 1'b1;
                        nxt.phase = PH_START;
                    end
                end
            end
            KIND_LOAD: begin
                if (it.module_index < NMOD) begin
                    nxt.counts[it.module_index] = it.load_count;
                    nxt.masks[it.module_index] = it.load_slot_mask & SLOT_BITS;
                end
            end
            default: begin
            end
        endcase
        return hit;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_cnt < 40) $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        err_cnt++;
    endtask

    task automatic check_event(input result_t got);
        result_t want;
        if (due_events.size() == 0) begin
            report_mismatch($sformatf("event %0d module %0d with nothing expected",
                                      got.event_res, got.module_number));
        end else begin
            want = due_events.pop_front();
            if (got.event_res !== want.event_res)
                report_mismatch($sformatf("event_res %0d, want %0d", got.event_res, want.event_res));
            if (got.module_number !== want.module_number)
                report_mismatch($sformatf("module_number %0d, want %0d",
                                          got.module_number, want.module_number));
            if (got.count_left !== want.count_left)
                report_mismatch($sformatf("count_left %0d, want %0d",
                                          got.count_left, want.count_left));
            if (got.from_remote !== want.from_remote)
                report_mismatch($sformatf("from_remote %0d, want %0d",
                                          got.from_remote, want.from_remote));
            if (got.job_slot !== want.job_slot)
                report_mismatch($sformatf("job_slot %0d, want %0d", got.job_slot, want.job_slot));
        end
    endtask

    // driver: predicts on acceptance, then presents the next item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (next_event(chk_seq, cur_cmd, chk_next, chk_ev)) due_events.push_back(chk_ev);
                chk_seq = chk_next;
            end
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
                    cur_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, cur_cmd.load_slot_mask, cur_cmd.load_count,
                                cur_cmd.servo_ok, cur_cmd.module_index, cur_cmd.slot_index};
                    s_tuser <= cur_cmd.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_event({m_tuser, m_tdata[3:0], m_tdata[11:4], m_tdata[12], m_tdata[15:13]});
            m_tready <= calm || $urandom_range(99) >= 15;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("dispense_job_sequencer_top_tb: errors");
            $finish;
        end
    end

    task automatic push_cmd(input item_t it);
        seq_state_t nx;
        result_t ev;
        bit hit;
        hit = next_event(gen_seq, it, nx, ev);
        gen_seq = nx;
        cmd_q.push_back(it);
        phase_items++;
    endtask

    function automatic item_t make_item(input logic [KIND_W-1:0] kind);
        logic [31:0] w;
        item_t it;
        w = $urandom;
        it = w[25:0];
        it.kind = kind;
        return it;
    endfunction

    task automatic push_fields(input logic [KIND_W-1:0] kind, input int slot, input int mod,
                               input bit ok, input int cnt, input int mask);
        item_t it;
        it.kind = kind;
        it.slot_index = 3'(slot);
        it.module_index = 4'(mod);
        it.servo_ok = ok;
        it.load_count = 8'(cnt);
        it.load_slot_mask = 7'(mask);
        push_cmd(it);
    endtask

    task automatic load_random();
        item_t it;
        it = make_item(KIND_LOAD);
        it.module_index = ($urandom_range(9) == 0) ? 4'($urandom_range(15, NMOD))
                                                    : 4'($urandom_range(NMOD - 1));
        case ($urandom_range(9))
            0: it.load_count = '0;
            1: it.load_count = '1;
            2: it.load_count = 8'd1;
            default: it.load_count = 8'($urandom_range(20, 2));
        endcase
        push_cmd(it);
    endtask

    task automatic push_noise();
        item_t it;
        it = make_item(3'($urandom_range(KIND_TOP)));
        push_cmd(it);
    endtask

    // ticks and servo reports until the job is back home, with some stray items mixed in
    task automatic run_to_home();
        item_t it;
        while (gen_seq.running) begin
            if ($urandom_range(99) < 8) begin
                push_noise();
            end else if (gen_seq.phase == PH_WAIT_SERVO) begin
                it = make_item(KIND_SERVO);
                it.servo_ok = ($urandom_range(99) < 75);
                push_cmd(it);
            end else begin
                push_cmd(make_item(KIND_TICK));
            end
        end
    endtask

    task automatic start_job();
        item_t it;
        int base;
        int k;
        repeat ($urandom_range(3)) load_random();
        if ($urandom_range(99) < 55) begin
            it = make_item(KIND_SLOT);
            it.slot_index = ($urandom_range(19) == 0) ? 3'(NSLOT) : 3'($urandom_range(NSLOT - 1));
        end else begin
            it = make_item(KIND_REMOTE);
            it.module_index = 4'($urandom_range(15));
            if ($urandom_range(99) < 85) begin
                // prefer a module that has pills so the request goes through
                base = $urandom_range(NMOD - 1);
                for (k = NMOD - 1; k >= 0; k--) begin
                    if (gen_seq.counts[(base + k) % NMOD] != '0)
                        it.module_index = 4'((base + k) % NMOD);
                end
            end
        end
        push_cmd(it);
        run_to_home();
    endtask

    task automatic run_mixed(input int budget);
        phase_items = 0;
        while (phase_items < budget) begin
            if ($urandom_range(99) < 80) begin
                start_job();
            end else begin
                push_noise();
            end
        end
        run_to_home();
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (cmd_q.size() != 0 || s_tvalid || due_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        gen_seq.hold_cfg = v;
        chk_seq.hold_cfg = v;
        @(negedge aclk);
    endtask

    initial begin
        item_t it;
        gen_seq = '0;
        gen_seq.hold_cfg = HOLD_RESET;
        gen_seq.phase = PH_IDLE;
        chk_seq = gen_seq;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, hold time still at its reset value
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        push_fields(KIND_SERVO, 0, 0, 1, 0, 0);
        it = '1;
        it.kind = KIND_TOP;
        push_cmd(it);
        push_fields(KIND_REMOTE, 0, 2, 0, 0, 0);
        push_fields(KIND_REMOTE, 7, 15, 1, 255, 127);
        it = '1;
        it.kind = KIND_LOAD;
        push_cmd(it);
        push_fields(KIND_LOAD, 0, 0, 0, 255, 127);
        push_fields(KIND_LOAD, 0, NMOD - 1, 0, 1, 1 << (NSLOT - 1));
        push_fields(KIND_LOAD, 0, 3, 1, 0, 127);
        push_fields(KIND_SLOT, NSLOT, 0, 0, 0, 0);
        push_fields(KIND_SLOT, NSLOT - 1, 0, 0, 0, 0);
        push_fields(KIND_SLOT, 0, 0, 0, 0, 0);
        push_fields(KIND_REMOTE, 0, 0, 0, 0, 0);
        push_fields(KIND_SERVO, 0, 0, 1, 0, 0);
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        push_fields(KIND_SERVO, 0, 0, 1, 0, 0);
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        // empty the module being served so the success finds no pill
        push_fields(KIND_LOAD, 0, NMOD - 1, 0, 0, 1 << (NSLOT - 1));
        push_fields(KIND_SERVO, 0, 0, 1, 0, 0);
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        // hold part way under the long reset hold, then cut it short
        repeat (40) push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        write_hold(12'd1);
        run_to_home();

        write_hold(12'd1);
        push_fields(KIND_REMOTE, 0, 0, 0, 0, 0);
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        push_fields(KIND_SERVO, 0, 0, 0, 0, 0);
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        run_mixed(300);

        write_hold(12'd0);
        run_mixed(250);

        write_hold(12'd2);
        run_mixed(300);

        write_hold(12'($urandom_range(40, 3)));
        run_mixed(550);

        // longest hold: a single job held part way, then a short hold ends it
        write_hold(12'hFFF);
        it = make_item(KIND_LOAD);
        it.module_index = 4'($urandom_range(NMOD - 1));
        it.load_count = 8'($urandom_range(255, 1));
        push_cmd(it);
        push_fields(KIND_REMOTE, 0, it.module_index, 0, 0, 0);
        push_fields(KIND_TICK, 0, 0, 0, 0, 0);
        push_fields(KIND_SERVO, 0, 0, 1, 0, 0);
        repeat (40) push_fields(KIND_TICK, 0, 0, 0, 0, 0);

        write_hold(12'($urandom_range(20, 1)));
        run_to_home();
        run_mixed(450);

        wait_idle();
        if (err_cnt == 0) begin
            $display("dispense_job_sequencer_top_tb: clean");
        end else begin
            $display("dispense_job_sequencer_top_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/djs_pkg.sv
design/djs_store.sv
design/djs_seq.sv
design/dispense_job_sequencer_top.sv
dv/dispense_job_sequencer_top_tb.sv
